FILE: rtl/core/deq_pkg.sv
// shared types, constants and helpers for the double-ended queue
`default_nettype none

package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int FUNC_W  = 3;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;
  localparam int ERR_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_CLEAR      = 3'd4,
    FN_QUERY      = 3'd5
  } deq_func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } deq_err_t;

  typedef logic [DATA_WIDTH-1:0] deq_word_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic [ERR_W-1:0]         error;
  } deq_out_t;

  // qualified commands broadcast to every cell
  typedef struct packed {
    logic put_front;
    logic put_back;
    logic take_front;
    logic take_back;
    logic clear;
  } deq_cmd_t;

  // low bits of the sign-extended request word
  function automatic deq_word_t word_in(logic signed [WORD_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

  // sign-extend a stored word and cut it to the result width
  function automatic logic signed [WORD_W-1:0] word_out(deq_word_t w);
    return WORD_W'(signed'(w));
  endfunction

endpackage : deq_pkg

`default_nettype wire

FILE: rtl/core/deq_cell.sv
// one storage cell of the deque row
`default_nettype none

module deq_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire deq_pkg::deq_cmd_t cmd,
  input  wire deq_pkg::deq_word_t wdata,
  input  wire deq_pkg::deq_word_t left_data,
  input  wire logic              left_occ,
  input  wire deq_pkg::deq_word_t right_data,
  input  wire logic              right_occ,
  output deq_pkg::deq_word_t     data,
  output logic                   occ
);
  import deq_pkg::*;

  deq_word_t data_r, data_nxt;
  logic      occ_r, occ_nxt;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (cmd.clear) begin
      occ_nxt = 1'b0;
    end else if (cmd.put_front) begin
      // whole row moves one place towards the back
      data_nxt = left_data;
      occ_nxt  = left_occ;
    end else if (cmd.put_back) begin
      // first free cell takes the word
      if (!occ_r && left_occ) begin
        data_nxt = wdata;
        occ_nxt  = 1'b1;
      end
    end else if (cmd.take_front) begin
      data_nxt = right_data;
      occ_nxt  = right_occ;
    end else if (cmd.take_back) begin
      if (occ_r && !right_occ) begin
        occ_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign data = data_r;
  assign occ  = occ_r;

endmodule : deq_cell

`default_nettype wire

FILE: rtl/core/deq_ctrl.sv
// request decode, element count and error tracking
`default_nettype none

module deq_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [deq_pkg::FUNC_W-1:0] func,
  output deq_pkg::deq_cmd_t               cmd,
  output logic [deq_pkg::CNT_W-1:0]       count,
  output logic [deq_pkg::ERR_W-1:0]       error,
  output logic                            rsp_valid
);
  import deq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  deq_err_t         err_r, err_nxt;
  logic             valid_r;
  logic             is_full, is_empty;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    cmd       = '0;
    count_nxt = count_r;
    err_nxt   = ERR_OK;
    unique case (func)
      FN_PUSH_FRONT: begin
        if (is_full) begin
          err_nxt = ERR_FULL;
        end else begin
          cmd.put_front = accept;
          count_nxt     = count_r + 1'b1;
        end
      end
      FN_PUSH_BACK: begin
        if (is_full) begin
          err_nxt = ERR_FULL;
        end else begin
          cmd.put_back = accept;
          count_nxt    = count_r + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (is_empty) begin
          err_nxt = ERR_EMPTY;
        end else begin
          cmd.take_front = accept;
          count_nxt      = count_r - 1'b1;
        end
      end
      FN_POP_BACK: begin
        if (is_empty) begin
          err_nxt = ERR_EMPTY;
        end else begin
          cmd.take_back = accept;
          count_nxt     = count_r - 1'b1;
        end
      end
      FN_CLEAR: begin
        cmd.clear = accept;
        count_nxt = '0;
      end
      default: begin
        // query and unused codes leave the count and cells alone and report no error
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= ERR_OK;
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  assign count     = count_r;
  assign error     = err_r;
  assign rsp_valid = valid_r;

endmodule : deq_ctrl

`default_nettype wire

FILE: rtl/core/double_ended_queue.sv
// top level of the double-ended queue built as a row of storage cells
`default_nettype none

// A bounded double-ended queue of DEPTH signed words. A request (start high
// while busy is low) names push front, push back, pop front, pop back, clear
// or query. busy is held low, so a request may be issued in every cycle;
// the row of cells shifts, fills or empties at the clock edge that accepts
// it, and exactly one result follows, shown for one cycle under out_valid
// in the cycle after acceptance. The receiver cannot stall the result. The
// result gives front and back words (zero when empty), the element count,
// an empty flag and an error code: a pop on an empty deque is ignored and
// flagged, a push on a full deque is dropped and flagged. Storage words are
// not reset; only the occupancy bits are.
module double_ended_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire deq_pkg::deq_in_t in_req,
  output logic                  out_valid,
  output deq_pkg::deq_out_t     out_rsp
);
  import deq_pkg::*;

  deq_cmd_t         cmd;
  logic [CNT_W-1:0] count;
  logic [ERR_W-1:0] error;
  logic             accept;
  deq_word_t        wdata;

  // cell row: element 0 is the front, occupancy is always a prefix
  deq_word_t        cell_data [DEPTH];
  logic [DEPTH-1:0] cell_occ;
  logic [DEPTH-1:0] cell_last;

  deq_word_t        front_w, back_w;

  // busy is tied low, so the block never refuses a request
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign wdata  = word_in(in_req.value);

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_req.func),
    .cmd       (cmd),
    .count     (count),
    .error     (error),
    .rsp_valid (out_valid)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_word_t l_data, r_data;
    logic      l_occ, r_occ;

    // the front cell sees the incoming word as its left neighbour
    if (i == 0) begin : g_first
      assign l_data = wdata;
      assign l_occ  = 1'b1;
    end else begin : g_mid
      assign l_data = cell_data[i-1];
      assign l_occ  = cell_occ[i-1];
    end

    // past the last cell nothing is stored
    if (i == DEPTH - 1) begin : g_tail
      assign r_data = cell_data[i];
      assign r_occ  = 1'b0;
    end else begin : g_body
      assign r_data = cell_data[i+1];
      assign r_occ  = cell_occ[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .wdata      (wdata),
      .left_data  (l_data),
      .left_occ   (l_occ),
      .right_data (r_data),
      .right_occ  (r_occ),
      .data       (cell_data[i]),
      .occ        (cell_occ[i])
    );

    // one-hot marker of the back element
    assign cell_last[i] = cell_occ[i] && !r_occ;
  end

  // front is cell 0; back is picked by the one-hot last marker
  always_comb begin
    front_w = cell_occ[0] ? cell_data[0] : '0;
    back_w  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_w = back_w | (cell_data[i] & {DATA_WIDTH{cell_last[i]}});
    end
  end

  assign out_rsp.front_word = word_out(front_w);
  assign out_rsp.back_word  = word_out(back_w);
  assign out_rsp.count      = COUNT_W'(count);
  assign out_rsp.is_empty   = !cell_occ[0];
  assign out_rsp.error      = error;

`ifndef SYNTHESIS
  // occupied cells form an unbroken run from the front
  a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_occ & (cell_occ + 1'b1)) == '0)
    else $error("deque cells occupied out of order");

  // the counter agrees with the cell row
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_occ) == int'(count))
    else $error("element count disagrees with cell occupancy");

  // every accepted request gives one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("missing result after request");

  // a full-deque error only ever reports a full row
  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (error == ERR_FULL)) |-> cell_occ[DEPTH-1])
    else $error("push rejected while deque not full");
`endif

endmodule : double_ended_queue

`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench for the double-ended queue: directed table, then random traffic
`timescale 1ns / 1ps

module tb_top;
  import deq_pkg::*;

  // spare operation codes, which the block must treat as a query
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  // bias of a random segment: towards filling, draining or neither
  typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;

  // one row of the directed table; reps > 1 repeats the row with value + i
  typedef struct {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] value;
    int                       reps;
    bit                       typed;
    deq_out_t                 want;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  deq_in_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  deq_out_t out_rsp;

  // shadow copy of the deque contents
  deq_word_t shadow_store [DEPTH];
  int        shadow_head = 0;
  int        shadow_count = 0;

  // status words still owed by the block, oldest first
  deq_out_t  awaited_status [$];
  int        mismatches = 0;

  plan_row_t plan [$];

  double_ended_queue u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // status after an operation on an empty deque
  function automatic deq_out_t empty_status(deq_err_t err);
    deq_out_t r;
    r = '0;
    r.is_empty = 1'b1;
    r.error    = err;
    return r;
  endfunction

  // apply one request to the shadow deque and return the status it should report
  function automatic deq_out_t deque_after(deq_in_t req);
    deq_out_t r;
    deq_err_t err;
    logic signed [DATA_WIDTH-1:0] fw;
    logic signed [DATA_WIDTH-1:0] bw;
    err = ERR_OK;
    r = '0;
    case (req.func)
      FN_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          err = ERR_FULL;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_store[shadow_head] = DATA_WIDTH'(req.value);
          shadow_count++;
        end
      end
      FN_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          err = ERR_FULL;
        end else begin
          shadow_store[(shadow_head + shadow_count) % DEPTH] = DATA_WIDTH'(req.value);
          shadow_count++;
        end
      end
      FN_POP_FRONT: begin
        if (shadow_count == 0) begin
          err = ERR_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      FN_POP_BACK: begin
        if (shadow_count == 0) err = ERR_EMPTY;
        else shadow_count--;
      end
      FN_CLEAR: begin
        shadow_count = 0;
        shadow_head  = 0;
      end
      default: ; // query and the spare codes leave the deque alone
    endcase
    if (shadow_count == 0) begin
      r.is_empty = 1'b1;
    end else begin
      // stored words are sign-extended from the storage width on the way out
      fw = shadow_store[shadow_head];
      bw = shadow_store[(shadow_head + shadow_count - 1) % DEPTH];
      r.front_word = fw;
      r.back_word  = bw;
    end
    r.count = COUNT_W'(shadow_count);
    r.error = err;
    return r;
  endfunction

  function automatic plan_row_t mk_row(logic [FUNC_W-1:0] func, logic signed [WORD_W-1:0] value,
                                       int reps, bit typed, deq_out_t want);
    plan_row_t p;
    p.func  = func;
    p.value = value;
    p.reps  = reps;
    p.typed = typed;
    p.want  = want;
    return p;
  endfunction

  // random idle length: mostly none or short, now and then a long one
  function automatic int gap_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // request word: mostly uniform, sometimes an extreme, zero or minus one
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(lean_t lean);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 97) return ($urandom_range(0, 1) != 0) ? FN_SPARE_7 : FN_SPARE_6;
    if (r >= 94) return FN_QUERY;
    if (r >= 91) return FN_CLEAR;
    case (lean)
      LEAN_FILL:  return (r < 32) ? FN_PUSH_FRONT : (r < 64) ? FN_PUSH_BACK :
                         (r < 78) ? FN_POP_FRONT  : FN_POP_BACK;
      LEAN_DRAIN: return (r < 14) ? FN_PUSH_FRONT : (r < 28) ? FN_PUSH_BACK :
                         (r < 60) ? FN_POP_FRONT  : FN_POP_BACK;
      default:    return (r < 23) ? FN_PUSH_FRONT : (r < 46) ? FN_PUSH_BACK :
                         (r < 69) ? FN_POP_FRONT  : FN_POP_BACK;
    endcase
  endfunction

  // hold one request on the ports until the block takes it, then log what it owes
  task automatic issue_request(logic [FUNC_W-1:0] func, logic signed [WORD_W-1:0] value,
                               bit typed, deq_out_t want);
    deq_in_t  req;
    deq_out_t predicted;
    req.func  = func;
    req.value = value;
    start  <= 1'b1;
    in_req <= req;
    // busy is sampled as it stood before the edge
    do @(posedge clk); while (busy);
    predicted = deque_after(req);
    awaited_status = {awaited_status, (typed ? want : predicted)};
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending until every owed status has come back
  task automatic hold_until_answered();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_status.size() != 0) @(posedge clk);
  endtask

  task automatic run_segment(int n, lean_t lean, bit quiet);
    for (int i = 0; i < n; i++) begin
      issue_request(pick_func(lean), pick_word(), 1'b0, '0);
      idle_for(gap_len(quiet));
    end
  endtask

  // result side: every strobe must match the oldest owed status, field by field
  always @(posedge clk) begin
    deq_out_t want;
    if (rst_n && out_valid) begin
      if (awaited_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: front %h back %h count %0d empty %b err %0d",
                   out_rsp.front_word, out_rsp.back_word, out_rsp.count,
                   out_rsp.is_empty, out_rsp.error);
      end else begin
        want = awaited_status[0];
        awaited_status.delete(0);
        if (out_rsp.front_word !== want.front_word || out_rsp.back_word !== want.back_word ||
            out_rsp.count !== want.count || out_rsp.is_empty !== want.is_empty ||
            out_rsp.error !== want.error) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected front %h back %h count %0d empty %b err %0d",
                     want.front_word, want.back_word, want.count, want.is_empty, want.error);
            $display("          actual   front %h back %h count %0d empty %b err %0d",
                     out_rsp.front_word, out_rsp.back_word, out_rsp.count,
                     out_rsp.is_empty, out_rsp.error);
          end
        end
      end
    end
  end

  initial begin
    // after reset: empty, and pops on empty are ignored and flagged
    plan = {plan, mk_row(FN_QUERY,      32'sh1234_5678, 1, 1'b1, empty_status(ERR_OK))};
    plan = {plan, mk_row(FN_POP_FRONT,  32'sh0,         1, 1'b1, empty_status(ERR_EMPTY))};
    plan = {plan, mk_row(FN_POP_BACK,   -32'sd1,        1, 1'b1, empty_status(ERR_EMPTY))};
    // extremes of the word, push front wraps the head below zero
    plan = {plan, mk_row(FN_PUSH_FRONT, 32'sh7fff_ffff, 1, 1'b0, '0)};
    plan = {plan, mk_row(FN_PUSH_BACK,  32'sh8000_0000, 1, 1'b0, '0)};
    // spare codes behave as a query
    plan = {plan, mk_row(FN_SPARE_6,    32'sh5a5a_5a5a, 1, 1'b0, '0)};
    plan = {plan, mk_row(FN_SPARE_7,    32'sha5a5_a5a5, 1, 1'b0, '0)};
    plan = {plan, mk_row(FN_POP_FRONT,  32'sh0,         1, 1'b0, '0)};
    plan = {plan, mk_row(FN_POP_BACK,   32'sh0,         1, 1'b0, '0)};
    plan = {plan, mk_row(FN_POP_FRONT,  32'sh0,         1, 1'b1, empty_status(ERR_EMPTY))};
    plan = {plan, mk_row(FN_PUSH_BACK,  -32'sd1,        1, 1'b0, '0)};
    plan = {plan, mk_row(FN_PUSH_FRONT, 32'sh0,         1, 1'b0, '0)};
    plan = {plan, mk_row(FN_CLEAR,      32'sh0,         1, 1'b1, empty_status(ERR_OK))};
    // fill to the brim from both ends, then pushes on full are dropped
    plan = {plan, mk_row(FN_PUSH_BACK,  32'sh1000_0000, 8, 1'b0, '0)};
    plan = {plan, mk_row(FN_PUSH_FRONT, 32'shf000_0000, 8, 1'b0, '0)};
    plan = {plan, mk_row(FN_PUSH_BACK,  32'sh7777_7777, 1, 1'b0, '0)};
    plan = {plan, mk_row(FN_PUSH_FRONT, 32'sh8888_8888, 1, 1'b0, '0)};
    plan = {plan, mk_row(FN_QUERY,      32'sh0,         1, 1'b0, '0)};
    plan = {plan, mk_row(FN_CLEAR,      32'sh0,         1, 1'b1, empty_status(ERR_OK))};
    plan = {plan, mk_row(FN_CLEAR,      32'sh0,         1, 1'b1, empty_status(ERR_OK))};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, with a few short gaps mixed in
    foreach (plan[k]) begin
      for (int i = 0; i < plan[k].reps; i++) begin
        issue_request(plan[k].func, plan[k].value + i, plan[k].typed, plan[k].want);
        idle_for(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      end
    end

    hold_until_answered();

    // random part: segments of differing bias, some with no idling at all
    run_segment(30, LEAN_FILL, 1'b0);
    for (int seg = 1; seg < 15; seg++) begin
      if (seg == 7) hold_until_answered();
      run_segment(30, lean_t'($urandom_range(0, 2)), (seg % 4) == 3);
    end

    hold_until_answered();
    repeat (5) @(posedge clk);

    if (mismatches == 0 && awaited_status.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (awaited_status.size() != 0)
        $display("%0d results never arrived", awaited_status.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
